/* rtl/spa_pkg.sv */
// Shared types, codes and the microcode program of the sparse polynomial accumulator.
package spa_pkg;

    // Default table depth
    localparam int MAX_TERMS_DEF = 32;

    // Operation codes of an input item
    localparam logic [1:0] FUNC_ADD   = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    // Input item
    typedef struct packed {
        logic [1:0]         func;
        logic signed [15:0] coef;
        logic signed [15:0] expo;
    } t_in_item;

    // Result item
    typedef struct packed {
        logic signed [31:0] out_coef;
        logic signed [15:0] out_expo;
        logic [5:0]         term_total;
        logic               overflow;
        logic               last;
    } t_out_item;

    // One stored term
    typedef struct packed {
        logic signed [31:0] coef;
        logic signed [15:0] expo;
    } t_term;

    // Branch conditions
    typedef enum logic [3:0] {
        C_NEVER = 4'd0,
        C_TRUE  = 4'd1,
        C_LESS  = 4'd2,   // index below count and stored exponent below operand
        C_MATCH = 4'd3,   // index below count and stored exponent equals operand
        C_FULL  = 4'd4,
        C_ABOVE = 4'd5,   // index differs from saved insert position
        C_LTCNT = 4'd6,
        C_EMPTY = 4'd7,
        C_MORE  = 4'd8,   // another term follows the current one
        C_NZSUM = 4'd9
    } t_cond;

    typedef enum logic [2:0] {
        IDX_HOLD = 3'd0,
        IDX_ZERO = 3'd1,
        IDX_INC  = 3'd2,
        IDX_DEC  = 3'd3,
        IDX_CNT  = 3'd4
    } t_idx_op;

    typedef enum logic [1:0] {
        WR_NONE  = 2'd0,
        WR_SHIFT = 2'd1,  // move read data
        WR_NEW   = 2'd2,  // new term from operands
        WR_SUM   = 2'd3   // merged coefficient
    } t_wr_op;

    typedef enum logic [1:0] {
        CNT_HOLD = 2'd0,
        CNT_INC  = 2'd1,
        CNT_DEC  = 2'd2,
        CNT_CLR  = 2'd3
    } t_cnt_op;

    typedef enum logic [2:0] {
        EM_NONE = 3'd0,
        EM_STAT = 3'd1,   // zero term, last
        EM_OVF  = 3'd2,   // zero term, last, overflow
        EM_TERM = 3'd3,   // stored term, more follow
        EM_LAST = 3'd4    // stored term, last
    } t_emit;

    // Step addresses
    localparam int STEP_W = 5;
    localparam logic [STEP_W-1:0] S_IDLE = 5'd0;
    localparam logic [STEP_W-1:0] S_A0   = 5'd1;
    localparam logic [STEP_W-1:0] S_A1   = 5'd2;
    localparam logic [STEP_W-1:0] S_A2   = 5'd3;
    localparam logic [STEP_W-1:0] S_A3   = 5'd4;
    localparam logic [STEP_W-1:0] S_A4   = 5'd5;
    localparam logic [STEP_W-1:0] S_A5   = 5'd6;
    localparam logic [STEP_W-1:0] S_A6   = 5'd7;
    localparam logic [STEP_W-1:0] S_OVF  = 5'd8;
    localparam logic [STEP_W-1:0] S_M0   = 5'd9;
    localparam logic [STEP_W-1:0] S_D0   = 5'd10;
    localparam logic [STEP_W-1:0] S_D1   = 5'd11;
    localparam logic [STEP_W-1:0] S_D2   = 5'd12;
    localparam logic [STEP_W-1:0] S_R0   = 5'd13;
    localparam logic [STEP_W-1:0] S_R1   = 5'd14;
    localparam logic [STEP_W-1:0] S_R2   = 5'd15;
    localparam logic [STEP_W-1:0] S_R3   = 5'd16;
    localparam logic [STEP_W-1:0] S_C0   = 5'd17;
    localparam logic [STEP_W-1:0] S_Z0   = 5'd18;

    // Control word: branch to target when cond holds, else fall through.
    // With gate set, the side effects apply only on a taken branch.
    typedef struct packed {
        t_cond              cond;
        logic               gate;
        logic [STEP_W-1:0]  target;
        t_idx_op            idx_op;
        logic               ra_m1;
        t_wr_op             wr_op;
        logic               wa_m1;
        t_cnt_op            cnt_op;
        logic               pos_ld;
        t_emit              emit;
    } t_uword;

    // Sequencer to datapath
    typedef struct packed {
        logic    load;
        t_idx_op idx_op;
        logic    ra_m1;
        t_wr_op  wr_op;
        logic    wa_m1;
        t_cnt_op cnt_op;
        logic    pos_ld;
        t_emit   emit;
    } t_ctrl;

    // Datapath to sequencer
    typedef struct packed {
        logic less;
        logic match;
        logic full;
        logic above;
        logic ltcnt;
        logic empty;
        logic more;
        logic nzsum;
    } t_flags;

    localparam t_uword UW_NOP = '{
        cond: C_TRUE, gate: 1'b0, target: S_IDLE, idx_op: IDX_HOLD, ra_m1: 1'b0,
        wr_op: WR_NONE, wa_m1: 1'b0, cnt_op: CNT_HOLD, pos_ld: 1'b0, emit: EM_NONE
    };

    // Microcode program
    function automatic t_uword ucode(input logic [STEP_W-1:0] step);
        t_uword w;
        w = UW_NOP;
        case (step)
            // add: start search at entry zero
            S_A0: begin
                w.cond   = C_NEVER;
                w.idx_op = IDX_ZERO;
            end
            // walk past smaller exponents
            S_A1: begin
                w.cond   = C_LESS;
                w.gate   = 1'b1;
                w.target = S_A1;
                w.idx_op = IDX_INC;
            end
            S_A2: begin
                w.cond   = C_MATCH;
                w.target = S_M0;
            end
            S_A3: begin
                w.cond   = C_FULL;
                w.target = S_OVF;
            end
            // insert: remember position, start shifting from the top
            S_A4: begin
                w.cond   = C_NEVER;
                w.pos_ld = 1'b1;
                w.idx_op = IDX_CNT;
                w.ra_m1  = 1'b1;
            end
            S_A5: begin
                w.cond   = C_ABOVE;
                w.gate   = 1'b1;
                w.target = S_A5;
                w.wr_op  = WR_SHIFT;
                w.idx_op = IDX_DEC;
                w.ra_m1  = 1'b1;
            end
            S_A6: begin
                w.wr_op  = WR_NEW;
                w.cnt_op = CNT_INC;
                w.emit   = EM_STAT;
            end
            S_OVF: begin
                w.emit = EM_OVF;
            end
            // merge: keep nonzero sum, else fall into delete
            S_M0: begin
                w.cond  = C_NZSUM;
                w.gate  = 1'b1;
                w.wr_op = WR_SUM;
                w.emit  = EM_STAT;
            end
            S_D0: begin
                w.cond   = C_NEVER;
                w.idx_op = IDX_INC;
            end
            S_D1: begin
                w.cond   = C_LTCNT;
                w.gate   = 1'b1;
                w.target = S_D1;
                w.wr_op  = WR_SHIFT;
                w.wa_m1  = 1'b1;
                w.idx_op = IDX_INC;
            end
            S_D2: begin
                w.cnt_op = CNT_DEC;
                w.emit   = EM_STAT;
            end
            // readout
            S_R0: begin
                w.cond   = C_NEVER;
                w.idx_op = IDX_ZERO;
            end
            S_R1: begin
                w.cond = C_EMPTY;
                w.gate = 1'b1;
                w.emit = EM_STAT;
            end
            S_R2: begin
                w.cond   = C_MORE;
                w.gate   = 1'b1;
                w.target = S_R2;
                w.idx_op = IDX_INC;
                w.emit   = EM_TERM;
            end
            S_R3: begin
                w.emit = EM_LAST;
            end
            S_C0: begin
                w.cnt_op = CNT_CLR;
                w.emit   = EM_STAT;
            end
            S_Z0: begin
                w.emit = EM_STAT;
            end
            default: begin
                w = UW_NOP;
            end
        endcase
        return w;
    endfunction

endpackage

/* rtl/spa_seq.sv */
// Microcode sequencer: step counter, program table lookup and branch logic.
module spa_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  spa_pkg::t_in_item i_in,
    input  spa_pkg::t_flags   i_flags,
    output spa_pkg::t_ctrl    o_ctrl,
    output logic              o_busy
);

    logic [spa_pkg::STEP_W-1:0] r_step;
    logic [spa_pkg::STEP_W-1:0] n_step;
    logic [spa_pkg::STEP_W-1:0] w_entry;
    spa_pkg::t_uword            w_word;
    logic                       w_taken;
    logic                       w_en;
    logic                       w_accept;

    assign w_word   = spa_pkg::ucode(r_step);
    assign o_busy   = (r_step != spa_pkg::S_IDLE);
    assign w_accept = i_start && !o_busy;

    // entry point by operation
    always_comb begin
        case (i_in.func)
            spa_pkg::FUNC_ADD:   w_entry = (i_in.coef != '0) ? spa_pkg::S_A0 : spa_pkg::S_Z0;
            spa_pkg::FUNC_READ:  w_entry = spa_pkg::S_R0;
            spa_pkg::FUNC_CLEAR: w_entry = spa_pkg::S_C0;
            default:             w_entry = spa_pkg::S_Z0;
        endcase
    end

    // branch condition select
    always_comb begin
        case (w_word.cond)
            spa_pkg::C_NEVER: w_taken = 1'b0;
            spa_pkg::C_TRUE:  w_taken = 1'b1;
            spa_pkg::C_LESS:  w_taken = i_flags.less;
            spa_pkg::C_MATCH: w_taken = i_flags.match;
            spa_pkg::C_FULL:  w_taken = i_flags.full;
            spa_pkg::C_ABOVE: w_taken = i_flags.above;
            spa_pkg::C_LTCNT: w_taken = i_flags.ltcnt;
            spa_pkg::C_EMPTY: w_taken = i_flags.empty;
            spa_pkg::C_MORE:  w_taken = i_flags.more;
            spa_pkg::C_NZSUM: w_taken = i_flags.nzsum;
            default:          w_taken = 1'b0;
        endcase
    end

    // next step
    always_comb begin
        if (!o_busy) begin
            n_step = w_accept ? w_entry : spa_pkg::S_IDLE;
        end else if (w_taken) begin
            n_step = w_word.target;
        end else begin
            n_step = r_step + 1'b1;
        end
    end

    // datapath controls, gated words act only on a taken branch
    assign w_en = !w_word.gate || w_taken;
    always_comb begin
        o_ctrl.load   = w_accept;
        o_ctrl.ra_m1  = w_word.ra_m1;
        o_ctrl.wa_m1  = w_word.wa_m1;
        o_ctrl.idx_op = w_en ? w_word.idx_op : spa_pkg::IDX_HOLD;
        o_ctrl.wr_op  = w_en ? w_word.wr_op  : spa_pkg::WR_NONE;
        o_ctrl.cnt_op = w_en ? w_word.cnt_op : spa_pkg::CNT_HOLD;
        o_ctrl.pos_ld = w_en && w_word.pos_ld;
        o_ctrl.emit   = w_en ? w_word.emit   : spa_pkg::EM_NONE;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= spa_pkg::S_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

/* rtl/spa_dp.sv */
// Datapath: term memory, index/position/count registers, adder and result register.
module spa_dp #(
    parameter int MAX_TERMS = spa_pkg::MAX_TERMS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  spa_pkg::t_in_item  i_in,
    input  spa_pkg::t_ctrl     i_ctrl,
    output spa_pkg::t_flags    o_flags,
    output logic               o_valid,
    output spa_pkg::t_out_item o_out
);

    localparam int IW = $clog2(MAX_TERMS + 1);
    localparam int AW = $clog2(MAX_TERMS);

    spa_pkg::t_term     r_terms [MAX_TERMS];
    spa_pkg::t_term     r_rd;
    logic [IW-1:0]      r_idx;
    logic [IW-1:0]      n_idx;
    logic [IW-1:0]      r_pos;
    logic [IW-1:0]      r_cnt;
    logic [IW-1:0]      n_cnt;
    logic signed [15:0] r_coef;
    logic signed [15:0] r_expo;
    logic               r_valid;
    spa_pkg::t_out_item r_out;
    spa_pkg::t_out_item n_out;

    logic [IW-1:0]      w_ra_full;
    logic [IW-1:0]      w_wa_full;
    logic [AW-1:0]      w_ra;
    logic [AW-1:0]      w_wa;
    logic               w_we;
    spa_pkg::t_term     w_wd;
    logic signed [32:0] w_sum;
    logic signed [31:0] w_sat;
    logic [IW:0]        w_idx_p1;
    logic [IW+5:0]      w_cnt_ext;

    // merge sum with clamp to the 32-bit range
    assign w_sum = {r_rd.coef[31], r_rd.coef} + 33'(r_coef);
    always_comb begin
        if (w_sum[32] != w_sum[31]) begin
            w_sat = w_sum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end else begin
            w_sat = w_sum[31:0];
        end
    end

    // status to the sequencer
    assign w_idx_p1      = {1'b0, r_idx} + 1'b1;
    assign o_flags.ltcnt = (r_idx < r_cnt);
    assign o_flags.less  = o_flags.ltcnt && (r_rd.expo < r_expo);
    assign o_flags.match = o_flags.ltcnt && (r_rd.expo == r_expo);
    assign o_flags.full  = (r_cnt == IW'(MAX_TERMS));
    assign o_flags.above = (r_idx != r_pos);
    assign o_flags.empty = (r_cnt == '0);
    assign o_flags.more  = (w_idx_p1 < {1'b0, r_cnt});
    assign o_flags.nzsum = (w_sat != '0);

    // index update
    always_comb begin
        case (i_ctrl.idx_op)
            spa_pkg::IDX_HOLD: n_idx = r_idx;
            spa_pkg::IDX_ZERO: n_idx = '0;
            spa_pkg::IDX_INC:  n_idx = r_idx + 1'b1;
            spa_pkg::IDX_DEC:  n_idx = r_idx - 1'b1;
            spa_pkg::IDX_CNT:  n_idx = r_cnt;
            default:           n_idx = r_idx;
        endcase
    end

    // count update
    always_comb begin
        case (i_ctrl.cnt_op)
            spa_pkg::CNT_HOLD: n_cnt = r_cnt;
            spa_pkg::CNT_INC:  n_cnt = r_cnt + 1'b1;
            spa_pkg::CNT_DEC:  n_cnt = r_cnt - 1'b1;
            spa_pkg::CNT_CLR:  n_cnt = '0;
            default:           n_cnt = r_cnt;
        endcase
    end

    // memory addressing: read follows the next index so data lines up
    assign w_ra_full = i_ctrl.ra_m1 ? (n_idx - 1'b1) : n_idx;
    assign w_wa_full = i_ctrl.wa_m1 ? (r_idx - 1'b1) : r_idx;
    assign w_ra      = w_ra_full[AW-1:0];
    assign w_wa      = w_wa_full[AW-1:0];
    assign w_we      = (i_ctrl.wr_op != spa_pkg::WR_NONE);

    always_comb begin
        case (i_ctrl.wr_op)
            spa_pkg::WR_SHIFT: w_wd = r_rd;
            spa_pkg::WR_NEW:   w_wd = '{coef: 32'(r_coef), expo: r_expo};
            spa_pkg::WR_SUM:   w_wd = '{coef: w_sat, expo: r_rd.expo};
            default:           w_wd = r_rd;
        endcase
    end

    // term memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_terms[w_wa] <= w_wd;
        end
        r_rd <= r_terms[w_ra];
    end

    // result assembly
    assign w_cnt_ext = {6'd0, n_cnt};
    always_comb begin
        n_out.term_total = w_cnt_ext[5:0];
        n_out.overflow   = (i_ctrl.emit == spa_pkg::EM_OVF);
        n_out.last       = (i_ctrl.emit != spa_pkg::EM_TERM);
        if (i_ctrl.emit == spa_pkg::EM_TERM || i_ctrl.emit == spa_pkg::EM_LAST) begin
            n_out.out_coef = r_rd.coef;
            n_out.out_expo = r_rd.expo;
        end else begin
            n_out.out_coef = '0;
            n_out.out_expo = '0;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_cnt   <= n_cnt;
            r_valid <= (i_ctrl.emit != spa_pkg::EM_NONE);
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_out <= n_out;
        if (i_ctrl.pos_ld) begin
            r_pos <= r_idx;
        end
        if (i_ctrl.load) begin
            r_coef <= i_in.coef;
            r_expo <= i_in.expo;
        end
    end

    assign o_valid = r_valid;
    assign o_out   = r_out;

endmodule

/* rtl/sparse_polynomial_accumulator.sv */
// Top level of the sparse polynomial accumulator: sequencer plus datapath.
// Add: a search walk and then a shift walk, one entry per cycle through the term memory with
//   its separate read and write ports; the n stored terms bound the length of both walks.
// Readout of n terms gives one result per term, the last one flagged last; empty readout, clear
//   and ignored items give a single status result. busy drops in the cycle of the last result.
// Results are one-cycle strobes; synchronous active-low reset empties the table and idles the block.
module sparse_polynomial_accumulator #(
    parameter int MAX_TERMS = spa_pkg::MAX_TERMS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  spa_pkg::t_in_item  i_in,
    output logic               busy,
    output logic               o_valid,
    output spa_pkg::t_out_item o_out
);

    spa_pkg::t_ctrl  w_ctrl;
    spa_pkg::t_flags w_flags;

    // program sequencer
    spa_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_in    (i_in),
        .i_flags (w_flags),
        .o_ctrl  (w_ctrl),
        .o_busy  (busy)
    );

    // term storage and arithmetic
    spa_dp #(
        .MAX_TERMS (MAX_TERMS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_ctrl  (w_ctrl),
        .o_flags (w_flags),
        .o_valid (o_valid),
        .o_out   (o_out)
    );

endmodule

/* rtl/spa_chk.sv */
// Port-level checker for the sparse polynomial accumulator, bound to the top level.
module spa_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic               o_valid,
    input spa_pkg::t_out_item o_out
);

    // an accepted transfer keeps the block busy in the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    // the final result of an item frees the block in the same cycle
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out.last) |-> !busy)
        else $error("busy still high with final result");

    // readout terms before the final one arrive while the item is still in progress
    a_stream: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_out.last) |-> busy)
        else $error("non-final result after item ended");

    // a dropped add reports a single zero term
    a_ovf_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out.overflow) |-> (o_out.last && o_out.out_coef == '0
                                         && o_out.out_expo == '0))
        else $error("overflow result malformed");

endmodule

bind sparse_polynomial_accumulator spa_chk u_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_valid (o_valid),
    .o_out   (o_out)
);
